FILE: rtl/ltem_pkg.sv
// Package for the linear to exponential range mapper.
// Holds register codes, status codes, the configuration sequencer states,
// the configuration view struct and the exp2 table generator. No dependencies.
`default_nettype none

package ltem_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int EXP_ADDR_BITS_DEF = 8;
  localparam int EXP_TAB_MAX       = 4097;

  localparam logic [2:0] REG_SRC_LOW  = 3'd0;
  localparam logic [2:0] REG_SRC_HIGH = 3'd1;
  localparam logic [2:0] REG_DST_LOW  = 3'd2;
  localparam logic [2:0] REG_DST_HIGH = 3'd3;

  localparam logic [23:0] SRC_LOW_RST  = 24'd0;
  localparam logic [23:0] SRC_HIGH_RST = 24'd65536;
  localparam logic [23:0] DST_LOW_RST  = 24'd65536;
  localparam logic [23:0] DST_HIGH_RST = 24'd131072;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [38:0] LIM40   = {39{1'b1}};
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [3:0] {
    CFG_IDLE,
    CFG_START,
    CFG_DIV,
    CFG_SAT,
    CFG_OFS_LO,
    CFG_OFS_HI,
    CFG_OFS_FIN,
    CFG_NORM,
    CFG_SQR,
    CFG_NEXT_OP
  } cfg_fsm_t;

  typedef struct packed {
    logic [38:0]        recip_mag;
    logic               recip_neg;
    logic signed [39:0] offset;
    logic signed [31:0] log2;
    logic [23:0]        dl_mag;
    logic               dl_neg;
    logic               bad;
  } cfg_view_t;

  typedef logic [31:0] exp_tab_t [0:EXP_TAB_MAX-1];

  // 2^(i/2^abits) in Q1.30, truncated Taylor series of exp(i*ln2/2^abits)
  function automatic exp_tab_t exp_table(input int abits);
    exp_tab_t    tab;
    logic [63:0] x;
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    logic        stop;
    tab = '{default: '0};
    for (int i = 0; i <= (1 << abits); i++) begin
      x    = 64'(i) << (30 - abits);
      z    = (x * LN2_Q30) >> 30;
      sum  = ONE_Q30;
      term = ONE_Q30;
      stop = 1'b0;
      for (int n = 1; n < 40; n++) begin
        if (!stop) begin
          term = ((term * z) >> 30) / 64'(n);
          if (term == 64'd0) begin
            stop = 1'b1;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[i] = sum[31:0];
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lin_to_exp_range_map_unit.sv
// Linear to exponential range mapper, top level: 14-stage sample pipeline.
// Depends on ltem_pkg and ltem_cfg.
//
// Usage:
//   Samples enter on in_valid/in_ready (sample, end_of_block); mapped words
//   leave on out_valid/out_ready (mapped, status, block_end), one per sample.
//   Range registers are written through cfg_we/cfg_index/cfg_data.
//   Throughput: one sample per cycle while the sequencer is idle and the
//   receiver takes words; every stage has its own valid bit and fills empty
//   slots, so the input keeps flowing while a word waits. When the receiver
//   stalls, the pipeline fills up and in_ready drops only once no slot is
//   free; nothing is lost or repeated.
//   Reset and every register write start the constant sequencer: a restoring
//   divider for the reciprocal range, the offset in CFG_OFS_LO, CFG_OFS_HI
//   and CFG_OFS_FIN, then log2 of both destination bounds by repeated
//   squaring, during which in_ready is held low.
//   A degenerate configuration skips the sequencer and gives mapped 0, status 2.
`default_nettype none

module lin_to_exp_range_map_unit #(
  parameter int FRAC_BITS           = ltem_pkg::FRAC_BITS_DEF,
  parameter int EXP_TABLE_ADDR_BITS = ltem_pkg::EXP_ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] sample,
  input  wire logic        end_of_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      mapped,
  output logic [1:0]       status,
  output logic             block_end
);

  localparam int NS     = 14;
  localparam int A      = EXP_TABLE_ADDR_BITS;
  localparam int RB     = 24 - A;
  localparam int TM_W   = 64 - FRAC_BITS;
  localparam int T_W    = TM_W + 2;
  localparam int TMAG_W = T_W - 1;
  localparam int TH_W   = TMAG_W - 29;
  localparam int PW     = TMAG_W + 30;

  localparam ltem_pkg::exp_tab_t EXP_TAB = ltem_pkg::exp_table(EXP_TABLE_ADDR_BITS);

  ltem_pkg::cfg_view_t cv;
  logic                busy;

  ltem_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .view      (cv)
  );

  logic [NS:1] v, rdy, eob;
  logic        in_fire;

  always_comb begin
    rdy[NS] = out_ready || !v[NS];
    for (int i = NS - 1; i >= 1; i--) rdy[i] = !v[i] || rdy[i+1];
  end

  assign in_ready = rdy[1] && !busy;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_fire;
      for (int i = 2; i <= NS; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage payloads
  logic [43:0]           s1_pl;
  logic [42:0]           s1_ph;
  logic                  s1_neg;
  logic [TM_W-1:0]       s2_tm;
  logic                  s2_neg;
  logic signed [T_W-1:0] s3_t;
  logic [TMAG_W-1:0]     s4_tmag;
  logic                  s4_neg;
  logic [58:0]           s5_pa;
  logic [TH_W+29:0]      s5_pb;
  logic                  s5_neg;
  logic [PW-1:0]         s6_p;
  logic                  s6_neg;
  logic [30:0]           s7_em;
  logic                  s7_neg;
  logic [31:0]           s8_ue;
  logic [31:0]           s9_t0, s9_t1;
  logic [RB-1:0]         s9_rem;
  logic [7:0]            s9_kb;
  logic [31:0]           s10_t0, s10_d;
  logic [RB-1:0]         s10_rem;
  logic [7:0]            s10_kb;
  logic [31:0]           s11_t0;
  logic [31+RB:0]        s11_prod;
  logic [7:0]            s11_kb;
  logic [31:0]           s12_y;
  logic [7:0]            s12_kb;
  logic [55:0]           s13_mag;
  logic [7:0]            s13_kb;
  logic [31:0]           s14_mapped;
  logic [1:0]            s14_status;

  logic [23:0]           xm;
  logic [63:0]           p2;
  logic [63:0]           tm2;
  logic signed [T_W-1:0] t3m, ofs3;
  logic [29:0]           lmag;
  logic [PW:0]           pr7;
  logic [PW-32:0]        em7;
  logic [A:0]            idx0, idx1;
  logic [31:0]           lim;
  logic [7:0]            ls, sh;
  logic [89:0]           wide;
  logic [64:0]           rnd;
  logic [31:0]           r14;
  logic                  sat14;

  always_comb begin
    xm   = sample[23] ? 24'(-sample) : sample;
    p2   = 64'(s1_pl) + (64'(s1_ph) << 20);
    tm2  = (p2 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    t3m  = $signed({2'b00, s2_tm});
    ofs3 = T_W'(cv.offset);
    lmag = cv.log2[31] ? 30'(-cv.log2) : cv.log2[29:0];
    pr7  = (PW+1)'(s6_p) + ((PW+1)'(1) << 31);
    em7  = pr7[PW:32];
    idx0 = {1'b0, s8_ue[23:RB]};
    idx1 = idx0 + (A+1)'(1);
    lim  = cv.dl_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    ls   = s13_kb - 8'd94;
    sh   = 8'd94 - s13_kb;
    wide = 90'(s13_mag) << ls;
    rnd  = (65'(s13_mag) + (65'd1 << (sh - 8'd1))) >> sh;
    r14  = '0;
    sat14 = 1'b0;
    if (s13_kb >= 8'd94) begin
      if (wide > 90'(lim)) begin
        r14   = lim;
        sat14 = 1'b1;
      end else begin
        r14 = wide[31:0];
      end
    end else if (sh >= 8'd64) begin
      r14 = '0;
    end else if (rnd > 65'(lim)) begin
      r14   = lim;
      sat14 = 1'b1;
    end else begin
      r14 = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_pl  <= 44'(xm) * 44'(cv.recip_mag[19:0]);
      s1_ph  <= 43'(xm) * 43'(cv.recip_mag[38:20]);
      s1_neg <= sample[23] ^ cv.recip_neg;
      eob[1] <= end_of_block;
    end
    if (rdy[2]) begin
      s2_tm  <= tm2[TM_W-1:0];
      s2_neg <= s1_neg;
      eob[2] <= eob[1];
    end
    if (rdy[3]) begin
      s3_t   <= (s2_neg ? -t3m : t3m) + ofs3;
      eob[3] <= eob[2];
    end
    if (rdy[4]) begin
      s4_tmag <= s3_t[T_W-1] ? TMAG_W'(-s3_t) : s3_t[TMAG_W-1:0];
      s4_neg  <= s3_t[T_W-1] ^ cv.log2[31];
      eob[4]  <= eob[3];
    end
    if (rdy[5]) begin
      s5_pa  <= 59'(s4_tmag[28:0]) * 59'(lmag);
      s5_pb  <= (TH_W+30)'(s4_tmag[TMAG_W-1:29]) * (TH_W+30)'(lmag);
      s5_neg <= s4_neg;
      eob[5] <= eob[4];
    end
    if (rdy[6]) begin
      s6_p   <= PW'(s5_pa) + (PW'(s5_pb) << 29);
      s6_neg <= s5_neg;
      eob[6] <= eob[5];
    end
    if (rdy[7]) begin
      s7_em  <= (em7 > (PW-31)'(1 << 30)) ? 31'(1 << 30) : em7[30:0];
      s7_neg <= s6_neg;
      eob[7] <= eob[6];
    end
    if (rdy[8]) begin
      s8_ue  <= s7_neg ? (32'(1 << 30) - 32'(s7_em)) : (32'(1 << 30) + 32'(s7_em));
      eob[8] <= eob[7];
    end
    if (rdy[9]) begin
      s9_t0  <= EXP_TAB[idx0];
      s9_t1  <= EXP_TAB[idx1];
      s9_rem <= s8_ue[RB-1:0];
      s9_kb  <= s8_ue[31:24];
      eob[9] <= eob[8];
    end
    if (rdy[10]) begin
      s10_t0  <= s9_t0;
      s10_d   <= s9_t1 - s9_t0;
      s10_rem <= s9_rem;
      s10_kb  <= s9_kb;
      eob[10] <= eob[9];
    end
    if (rdy[11]) begin
      s11_t0   <= s10_t0;
      s11_prod <= (32+RB)'(s10_d) * (32+RB)'(s10_rem);
      s11_kb   <= s10_kb;
      eob[11]  <= eob[10];
    end
    if (rdy[12]) begin
      s12_y   <= s11_t0 + 32'(s11_prod >> RB);
      s12_kb  <= s11_kb;
      eob[12] <= eob[11];
    end
    if (rdy[13]) begin
      s13_mag <= 56'(cv.dl_mag) * 56'(s12_y);
      s13_kb  <= s12_kb;
      eob[13] <= eob[12];
    end
    if (rdy[14]) begin
      if (cv.bad) begin
        s14_mapped <= '0;
        s14_status <= ltem_pkg::ST_BAD;
      end else begin
        s14_mapped <= cv.dl_neg ? 32'(-r14) : r14;
        s14_status <= sat14 ? ltem_pkg::ST_SAT : ltem_pkg::ST_OK;
      end
      eob[14] <= eob[13];
    end
  end

  assign out_valid = v[NS];
  assign mapped    = s14_mapped;
  assign status    = s14_status;
  assign block_end = eob[NS];

endmodule

`default_nettype wire

FILE: rtl/ltem_cfg.sv
// Configuration registers and the sequencer that derives the per-sample
// constants (reciprocal range, offset, log2 ratio). Depends on ltem_pkg.
`default_nettype none

module ltem_cfg #(
  parameter int FRAC_BITS = ltem_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [23:0]       cfg_data,
  output logic                   busy,
  output ltem_pkg::cfg_view_t    view
);

  localparam int NUM_W = 33 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  ltem_pkg::cfg_fsm_t state, state_next;

  logic [23:0]        src_low, src_high, dst_low, dst_high;
  logic [CNT_W-1:0]   cnt;
  logic [23:0]        ar;
  logic               rneg;
  logic [NUM_W-1:0]   num;
  logic [23:0]        rem;
  logic [38:0]        recip_mag;
  logic               recip_neg;
  logic [62:0]        acc;
  logic signed [39:0] offset;
  logic signed [31:0] log2;
  logic               bad;
  logic [30:0]        mant;
  logic [4:0]         p;
  logic [23:0]        frac;
  logic               op;
  logic [28:0]        log_hi;

  logic               wr_hit;
  logic signed [24:0] range_w;
  logic               bad_now;
  logic [24:0]        trial;
  logic               ge;
  logic [23:0]        rem_n;
  logic [23:0]        lo_mag, dh_mag, dl_mag;
  logic [62:0]        prod_lo, prod_hi;
  logic [63:0]        rr;
  logic [38:0]        rrs;
  logic               ofs_neg;
  logic [61:0]        sq_full;
  logic [31:0]        sq;
  logic [28:0]        lv;

  assign wr_hit  = cfg_we && (cfg_index <= ltem_pkg::REG_DST_HIGH);
  assign range_w = 25'($signed(src_high)) - 25'($signed(src_low));
  assign bad_now = (range_w == 25'sd0) || (dst_low == 24'd0) || (dst_high == 24'd0)
                   || (dst_low[23] != dst_high[23]);
  assign trial   = {rem, num[NUM_W-1]};
  assign ge      = trial >= {1'b0, ar};
  assign rem_n   = ge ? 24'(trial - {1'b0, ar}) : trial[23:0];
  assign lo_mag  = src_low[23] ? 24'(-src_low) : src_low;
  assign dh_mag  = dst_high[23] ? 24'(-dst_high) : dst_high;
  assign dl_mag  = dst_low[23] ? 24'(-dst_low) : dst_low;
  assign prod_lo = 63'(lo_mag) * 63'(recip_mag[19:0]);
  assign prod_hi = 63'(lo_mag) * 63'(recip_mag[38:20]);
  assign rr      = (64'(acc) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rrs     = (rr > 64'(ltem_pkg::LIM40)) ? ltem_pkg::LIM40 : rr[38:0];
  assign ofs_neg = (!src_low[23] && (src_low != 24'd0)) ^ rneg;
  assign sq_full = 62'(mant) * 62'(mant);
  assign sq      = sq_full[61:30];
  assign lv      = {p, frac};

  always_comb begin
    state_next = state;
    unique case (state)
      ltem_pkg::CFG_IDLE:    state_next = ltem_pkg::CFG_IDLE;
      ltem_pkg::CFG_START:   state_next = bad_now ? ltem_pkg::CFG_IDLE : ltem_pkg::CFG_DIV;
      ltem_pkg::CFG_DIV: begin
        if (cnt == CNT_W'(1)) state_next = ltem_pkg::CFG_SAT;
      end
      ltem_pkg::CFG_SAT:     state_next = ltem_pkg::CFG_OFS_LO;
      ltem_pkg::CFG_OFS_LO:  state_next = ltem_pkg::CFG_OFS_HI;
      ltem_pkg::CFG_OFS_HI:  state_next = ltem_pkg::CFG_OFS_FIN;
      ltem_pkg::CFG_OFS_FIN: state_next = ltem_pkg::CFG_NORM;
      ltem_pkg::CFG_NORM: begin
        if (mant[30]) state_next = ltem_pkg::CFG_SQR;
      end
      ltem_pkg::CFG_SQR: begin
        if (cnt == CNT_W'(1)) state_next = ltem_pkg::CFG_NEXT_OP;
      end
      ltem_pkg::CFG_NEXT_OP: state_next = op ? ltem_pkg::CFG_IDLE : ltem_pkg::CFG_NORM;
      default:               state_next = ltem_pkg::CFG_IDLE;
    endcase
    if (wr_hit) state_next = ltem_pkg::CFG_START;
  end

  always_comb begin
    busy           = (state != ltem_pkg::CFG_IDLE);
    view.recip_mag = recip_mag;
    view.recip_neg = recip_neg;
    view.offset    = offset;
    view.log2      = log2;
    view.dl_mag    = dl_mag;
    view.dl_neg    = dst_low[23];
    view.bad       = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ltem_pkg::CFG_START;
      src_low  <= ltem_pkg::SRC_LOW_RST;
      src_high <= ltem_pkg::SRC_HIGH_RST;
      dst_low  <= ltem_pkg::DST_LOW_RST;
      dst_high <= ltem_pkg::DST_HIGH_RST;
      bad      <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_hit) begin
        unique case (cfg_index)
          ltem_pkg::REG_SRC_LOW:  src_low  <= cfg_data;
          ltem_pkg::REG_SRC_HIGH: src_high <= cfg_data;
          ltem_pkg::REG_DST_LOW:  dst_low  <= cfg_data;
          ltem_pkg::REG_DST_HIGH: dst_high <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ltem_pkg::CFG_START: begin
          bad <= bad_now;
          if (bad_now) begin
            recip_mag <= '0;
            recip_neg <= 1'b0;
            offset    <= '0;
            log2      <= '0;
          end
          ar   <= range_w[24] ? 24'(-range_w) : range_w[23:0];
          rneg <= range_w[24];
          num  <= (NUM_W'(1) << (32 + FRAC_BITS))
                  + NUM_W'((range_w[24] ? 24'(-range_w) : range_w[23:0]) >> 1);
          rem  <= '0;
          cnt  <= CNT_W'(NUM_W);
        end
        ltem_pkg::CFG_DIV: begin
          num <= {num[NUM_W-2:0], ge};
          rem <= rem_n;
          cnt <= cnt - CNT_W'(1);
        end
        ltem_pkg::CFG_SAT: begin
          recip_mag <= (|num[NUM_W-1:39]) ? ltem_pkg::LIM40 : num[38:0];
          recip_neg <= rneg;
        end
        ltem_pkg::CFG_OFS_LO: acc <= prod_lo;
        ltem_pkg::CFG_OFS_HI: acc <= acc + (prod_hi << 20);
        ltem_pkg::CFG_OFS_FIN: begin
          offset <= ofs_neg ? -$signed({1'b0, rrs}) : $signed({1'b0, rrs});
          mant   <= {7'd0, dh_mag};
          p      <= 5'd30;
          op     <= 1'b0;
          frac   <= '0;
        end
        ltem_pkg::CFG_NORM: begin
          if (!mant[30]) begin
            mant <= {mant[29:0], 1'b0};
            p    <= p - 5'd1;
          end else begin
            cnt <= CNT_W'(24);
          end
        end
        ltem_pkg::CFG_SQR: begin
          mant <= sq[31] ? sq[31:1] : sq[30:0];
          frac <= {frac[22:0], sq[31]};
          cnt  <= cnt - CNT_W'(1);
        end
        ltem_pkg::CFG_NEXT_OP: begin
          if (!op) begin
            log_hi <= lv;
            mant   <= {7'd0, dl_mag};
            p      <= 5'd30;
            op     <= 1'b1;
          end else begin
            log2 <= $signed(32'(log_hi)) - $signed(32'(lv));
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
